FILE: src/att_pkg.sv
`default_nettype none
package att_pkg;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_TICK   = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_DISP   = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_CHECK  = 3'd4;
	localparam logic [2:0] S_HIT    = 3'd5;
	localparam logic [2:0] S_MISS   = 3'd6;
	localparam logic [2:0] S_RESULT = 3'd7;

	localparam logic [2:0] C_ALWAYS    = 3'd0;
	localparam logic [2:0] C_CLR_LAST  = 3'd1;
	localparam logic [2:0] C_ITEM      = 3'd2;
	localparam logic [2:0] C_NOT_SCAN  = 3'd3;
	localparam logic [2:0] C_SCAN_DONE = 3'd4;
	localparam logic [2:0] C_NO_HIT    = 3'd5;
	localparam logic [2:0] C_OUT_FREE  = 3'd6;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] key;
		logic [31:0] requested_size;
		logic [31:0] allocated_size;
		logic [15:0] line_number;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] slot_index;
		logic [6:0] used_count;
		logic       exhausted;
	} rsp_t;

	typedef struct packed {
		logic        used;
		logic [31:0] key;
		logic [31:0] requested;
		logic [31:0] allocated;
		logic [15:0] line;
		logic [7:0]  age;
	} row_t;

	typedef struct packed {
		logic clr_wr;
		logic accept;
		logic dispatch;
		logic scan;
		logic hit_wr;
		logic miss;
		logic emit;
	} ctl_t;

	typedef struct packed {
		ctl_t       ctl;
		logic [2:0] cond;
		logic [2:0] target;
		logic       stay;
	} ucode_t;

	typedef struct packed {
		logic clr_last;
		logic item;
		logic not_scan;
		logic scan_done;
		logic no_hit;
		logic out_free;
	} cond_t;

	function automatic ucode_t ucode_rom(input logic [2:0] pc);
		ucode_t w;
		w = '0;
		case (pc)
			S_CLEAR: begin
				w.ctl.clr_wr = 1'b1;
				w.cond = C_CLR_LAST;
				w.target = S_IDLE;
				w.stay = 1'b1;
			end
			S_IDLE: begin
				w.ctl.accept = 1'b1;
				w.cond = C_ITEM;
				w.target = S_DISP;
				w.stay = 1'b1;
			end
			S_DISP: begin
				w.ctl.dispatch = 1'b1;
				w.cond = C_NOT_SCAN;
				w.target = S_RESULT;
			end
			S_SCAN: begin
				w.ctl.scan = 1'b1;
				w.cond = C_SCAN_DONE;
				w.target = S_CHECK;
				w.stay = 1'b1;
			end
			S_CHECK: begin
				w.cond = C_NO_HIT;
				w.target = S_MISS;
			end
			S_HIT: begin
				w.ctl.hit_wr = 1'b1;
				w.cond = C_ALWAYS;
				w.target = S_RESULT;
			end
			S_MISS: begin
				w.ctl.miss = 1'b1;
				w.cond = C_ALWAYS;
				w.target = S_RESULT;
			end
			S_RESULT: begin
				w.ctl.emit = 1'b1;
				w.cond = C_OUT_FREE;
				w.target = S_IDLE;
				w.stay = 1'b1;
			end
			default: begin
				w.cond = C_ALWAYS;
				w.target = S_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

FILE: src/att_seq.sv
`default_nettype none
module att_seq
	import att_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cond_t cond,
	output ctl_t       ctl
);

	logic [2:0] pc_q;
	ucode_t     word;
	logic       take;

	assign word = ucode_rom(pc_q);
	assign ctl  = word.ctl;

	always_comb begin
		case (word.cond)
			C_ALWAYS:    take = 1'b1;
			C_CLR_LAST:  take = cond.clr_last;
			C_ITEM:      take = cond.item;
			C_NOT_SCAN:  take = cond.not_scan;
			C_SCAN_DONE: take = cond.scan_done;
			C_NO_HIT:    take = cond.no_hit;
			C_OUT_FREE:  take = cond.out_free;
			default:     take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_CLEAR;
		end else if (take) begin
			pc_q <= word.target;
		end else if (!word.stay) begin
			pc_q <= pc_q + 3'd1;
		end
	end

endmodule
`default_nettype wire

FILE: src/att_mem.sv
`default_nettype none
module att_mem
	import att_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire row_t          wr_row,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output row_t               rd_row
);

	row_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_row;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_row <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

FILE: src/allocation_tracking_table_core.sv
// Insert and delete pass through dispatch, scan, check, then hit or miss, then result;
// the scan reads one table row per cycle from the table memory.
// Age tick and the unused command go from dispatch straight to result. One item is in
// work at a time; the next item can be taken in the cycle after its result is loaded, and
// a stalled result holds the input.
// After arst_n is released, the table is cleared one row per cycle with req_stall high;
// all counters, the age stamp and the exhausted flag reset to zero.
`default_nettype none
module allocation_tracking_table_core
	import att_pkg::*;
#(
	parameter int TABLE_ENTRIES = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);
	localparam logic [AW:0]   ENDC = (AW + 1)'(TABLE_ENTRIES);

	ctl_t  ctl;
	cond_t cond;

	req_t          item_q;
	logic [AW:0]   cnt_q;
	logic          rd_vld_s1;
	logic [AW-1:0] rd_addr_s1;
	row_t          rd_row;
	logic          found_q;
	logic          hit_used_q;
	logic [AW-1:0] hit_idx_q;
	logic [CW-1:0] live_q;
	logic [7:0]    age_q;
	logic          full_q;
	logic [1:0]    status_q;
	logic [AW-1:0] idx_q;
	logic          out_valid_q;
	rsp_t          out_q;

	logic          match;
	logic          scan_done;
	logic          issue;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	row_t          wr_row;
	logic          out_free;
	logic [CW+6:0] live_ext;
	logic [AW+5:0] idx_ext;

	assign match = (item_q.command == CMD_INSERT) ? !rd_row.used : (rd_row.key == item_q.key);
	assign scan_done = rd_vld_s1 && (match || rd_addr_s1 == LAST);
	assign issue = ctl.scan && !scan_done && (cnt_q < ENDC);
	assign out_free = !out_valid_q || !rsp_stall;

	assign cond.clr_last  = (cnt_q[AW-1:0] == LAST);
	assign cond.item      = req_valid;
	assign cond.not_scan  = (item_q.command != CMD_INSERT) && (item_q.command != CMD_DELETE);
	assign cond.scan_done = scan_done;
	assign cond.no_hit    = !found_q;
	assign cond.out_free  = out_free;

	att_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cond   (cond),
		.ctl    (ctl)
	);

	always_comb begin
		wr_row = '0;
		if (ctl.hit_wr && item_q.command == CMD_INSERT) begin
			wr_row.used      = 1'b1;
			wr_row.key       = item_q.key;
			wr_row.requested = item_q.requested_size;
			wr_row.allocated = item_q.allocated_size;
			wr_row.line      = item_q.line_number;
			wr_row.age       = age_q;
		end
	end

	assign wr_en   = ctl.clr_wr || ctl.hit_wr;
	assign wr_addr = ctl.clr_wr ? cnt_q[AW-1:0] : hit_idx_q;

	att_mem #(
		.DEPTH (TABLE_ENTRIES),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_row  (wr_row),
		.rd_en   (issue),
		.rd_addr (cnt_q[AW-1:0]),
		.rd_row  (rd_row)
	);

	always_ff @(posedge clk) begin
		if (ctl.accept && req_valid) begin
			item_q <= req;
		end
		if (issue) begin
			rd_addr_s1 <= cnt_q[AW-1:0];
		end
		if (ctl.scan && rd_vld_s1 && match && !found_q) begin
			hit_idx_q  <= rd_addr_s1;
			hit_used_q <= rd_row.used;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
			live_q    <= '0;
			age_q     <= '0;
			full_q    <= 1'b0;
			status_q  <= ST_OK;
			idx_q     <= '0;
		end else begin
			rd_vld_s1 <= issue;
			if (ctl.clr_wr || issue) begin
				cnt_q <= cnt_q + (AW + 1)'(1);
			end
			if (ctl.dispatch) begin
				cnt_q    <= '0;
				found_q  <= 1'b0;
				status_q <= ST_OK;
				idx_q    <= '0;
				if (item_q.command == CMD_TICK) begin
					age_q <= age_q + 8'd1;
				end
			end
			if (ctl.scan && rd_vld_s1 && match) begin
				found_q <= 1'b1;
			end
			if (ctl.hit_wr) begin
				idx_q <= hit_idx_q;
				if (item_q.command == CMD_INSERT) begin
					live_q <= live_q + CW'(1);
				end else if (hit_used_q && live_q != '0) begin
					live_q <= live_q - CW'(1);
				end
			end
			if (ctl.miss) begin
				if (item_q.command == CMD_INSERT) begin
					status_q <= ST_FULL;
					full_q   <= 1'b1;
				end else begin
					status_q <= ST_NOT_FOUND;
				end
			end
		end
	end

	assign live_ext = (CW + 7)'(live_q);
	assign idx_ext  = (AW + 6)'(idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit && out_free) begin
			out_q.status     <= status_q;
			out_q.slot_index <= idx_ext[5:0];
			out_q.used_count <= live_ext[6:0];
			out_q.exhausted  <= full_q;
		end
	end

	assign req_stall = !ctl.accept;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

`ifndef SYNTHESIS
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= CW'(TABLE_ENTRIES))
		else $error("live count above table size");
	a_fail_index: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != ST_OK) |-> rsp.slot_index == 6'd0)
		else $error("failed item carries a slot index");
	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == ST_FULL) |-> rsp.exhausted)
		else $error("table full without exhausted flag");
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.scan || ctl.hit_wr || ctl.miss) |-> req_stall)
		else $error("item taken while another is in work");
`endif

endmodule
`default_nettype wire

FILE: sim/tb.sv
`default_nettype none
module tb;
	import att_pkg::*;

	localparam int TABLE_ENTRIES = 64;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int STUCK_LIMIT = 20000;
	localparam int PHASE_ITEMS = 150;
	localparam int TICK_BURST = 260;

	class alloc_table_model;
		row_t rows[TABLE_ENTRIES];
		logic [7:0] age_stamp;
		bit exhausted;
		int live;
		rsp_t expected_rsp[$];
		int mismatches;

		function new();
			foreach (rows[i]) rows[i] = '0;
			age_stamp = '0;
			exhausted = 1'b0;
			live = 0;
			mismatches = 0;
		endfunction

		function void apply_item(req_t it);
			rsp_t exp;
			int slot;
			bit hit;
			exp = '0;
			exp.status = ST_OK;
			slot = 0;
			hit = 1'b0;
			case (it.command)
				CMD_INSERT: begin
					for (int s = 0; s < TABLE_ENTRIES && !hit; s++) begin
						if (!rows[s].used) begin
							hit = 1'b1;
							slot = s;
						end
					end
					if (hit) begin
						rows[slot].used = 1'b1;
						rows[slot].key = it.key;
						rows[slot].requested = it.requested_size;
						rows[slot].allocated = it.allocated_size;
						rows[slot].line = it.line_number;
						rows[slot].age = age_stamp;
						live++;
					end else begin
						exhausted = 1'b1;
						exp.status = ST_FULL;
						slot = 0;
					end
				end
				CMD_DELETE: begin
					for (int s = 0; s < TABLE_ENTRIES && !hit; s++) begin
						if (rows[s].key == it.key) begin
							hit = 1'b1;
							slot = s;
						end
					end
					if (hit) begin
						if (rows[slot].used && live > 0)
							live--;
						rows[slot] = '0;
					end else begin
						exp.status = ST_NOT_FOUND;
						slot = 0;
					end
				end
				CMD_TICK: begin
					age_stamp = age_stamp + 8'd1;
				end
				default: begin
				end
			endcase
			exp.slot_index = 6'(slot);
			exp.used_count = 7'(live);
			exp.exhausted = exhausted;
			expected_rsp.push_back(exp);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(rsp_t got);
			rsp_t exp;
			if (expected_rsp.size() == 0) begin
				$error("unexpected result item: %p", got);
				mismatches++;
				return;
			end
			exp = expected_rsp.pop_front();
			compare_field("status", 32'(exp.status), 32'(got.status));
			compare_field("slot_index", 32'(exp.slot_index), 32'(got.slot_index));
			compare_field("used_count", 32'(exp.used_count), 32'(got.used_count));
			compare_field("exhausted", 32'(exp.exhausted), 32'(got.exhausted));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int stuck = 0;
	bit filling = 1'b1;
	alloc_table_model shadow;

	allocation_tracking_table_core #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < rx_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall)
				shadow.check_result(rsp);
			if (req_valid && !req_stall)
				shadow.apply_item(req);
			if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
				stuck = 0;
			else
				stuck = stuck + 1;
			if (stuck >= STUCK_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	function automatic req_t make_item(logic [1:0] cmd, logic [31:0] key, logic [31:0] rq,
			logic [31:0] al, logic [15:0] ln);
		req_t it;
		it.command = cmd;
		it.key = key;
		it.requested_size = rq;
		it.allocated_size = al;
		it.line_number = ln;
		return it;
	endfunction

	function automatic logic [31:0] pick_live_key();
		int start;
		int s;
		start = $urandom_range(TABLE_ENTRIES - 1);
		for (int n = 0; n < TABLE_ENTRIES; n++) begin
			s = (start + n) % TABLE_ENTRIES;
			if (shadow.rows[s].used)
				return shadow.rows[s].key;
		end
		return $urandom;
	endfunction

	function automatic req_t random_item();
		req_t it;
		int roll;
		it = make_item(CMD_TICK, $urandom, $urandom, $urandom, 16'($urandom));
		if (filling && shadow.live == TABLE_ENTRIES && $urandom_range(3) == 0)
			filling = 1'b0;
		else if (!filling && shadow.live <= 4)
			filling = 1'b1;
		roll = $urandom_range(99);
		if (roll < (filling ? 80 : 25)) begin
			it.command = CMD_INSERT;
			if ($urandom_range(3) == 0)
				it.key = $urandom_range(7);
		end else if (roll < 90) begin
			it.command = CMD_DELETE;
			roll = $urandom_range(99);
			if (roll < 65)
				it.key = pick_live_key();
			else if (roll < 80)
				it.key = '0;
			else if (roll < 90)
				it.key = $urandom_range(7);
		end else if (roll < 98) begin
			it.command = CMD_TICK;
		end else begin
			it.command = CMD_UNUSED;
		end
		return it;
	endfunction

	task automatic drive_item(input req_t it);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req <= it;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do
			@(negedge clk);
		while (shadow.expected_rsp.size() != 0);
	endtask

	task automatic run_directed();
		drive_item(make_item(CMD_DELETE, '0, '0, '0, '0));
		drive_item(make_item(CMD_DELETE, '1, '0, '0, '0));
		drive_item(make_item(CMD_INSERT, '1, '1, '1, '1));
		drive_item(make_item(CMD_INSERT, '0, '0, '0, '0));
		drive_item(make_item(CMD_INSERT, 32'h1234_5678, 32'd16, 32'd32, 16'd100));
		drive_item(make_item(CMD_INSERT, 32'h1234_5678, 32'd17, 32'd32, 16'd101));
		drive_item(make_item(CMD_DELETE, 32'h1234_5678, '0, '0, '0));
		drive_item(make_item(CMD_INSERT, 32'hAAAA_5555, 32'h5555_AAAA, 32'h8000_0000,
			16'h8001));
		drive_item(make_item(CMD_DELETE, '0, '1, '1, '1));
		drive_item(make_item(CMD_DELETE, '0, '0, '0, '0));
		drive_item(make_item(CMD_TICK, '0, '0, '0, '0));
		drive_item(make_item(CMD_UNUSED, '1, '1, '1, '1));
		drive_item(make_item(CMD_TICK, '1, '1, '1, '1));
		drive_item(make_item(CMD_DELETE, 32'h1234_5678, '0, '0, '0));
		drive_item(make_item(CMD_DELETE, 32'h1234_5678, '0, '0, '0));
		drive_item(make_item(CMD_INSERT, 32'h5555_5555, 32'h0000_0001, 32'h0000_0008,
			16'hFFFF));
		drive_item(make_item(CMD_DELETE, '1, '0, '0, '0));
	endtask

	initial begin
		shadow = new();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		run_directed();
		wait_drained();
		repeat (TICK_BURST)
			drive_item(make_item(CMD_TICK, $urandom, $urandom, $urandom, 16'($urandom)));
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					tx_idle_pct = 0;
					rx_stall_pct = 0;
				end
				1: begin
					tx_idle_pct = 67;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct = 67;
				end
				default: begin
					tx_idle_pct = 38;
					rx_stall_pct = 38;
				end
			endcase
			repeat (PHASE_ITEMS)
				drive_item(random_item());
			wait_drained();
		end
		repeat (2 * TABLE_ENTRIES) @(negedge clk);
		if (shadow.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire

FILE: allocation_tracking_table_core.f
src/att_pkg.sv
src/att_seq.sv
src/att_mem.sv
src/allocation_tracking_table_core.sv
sim/tb.sv
